>>> rtl/sha1e_pkg.sv
// Shared types, constants and round functions of the SHA-1 engine.
`timescale 1ns / 1ps

package sha1e_pkg;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned WORDS     = 5;
	localparam logic [5:0]  POS_LAST  = 6'd63;
	localparam logic [5:0]  POS_LEN   = 6'd56;
	localparam logic [6:0]  ROUND_END = 7'd79;
	localparam logic [2:0]  IDX_LAST  = 3'd4;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic       push;
		byte_src_t  src;
		logic [2:0] len_idx;
		logic       count;
		logic       load_work;
		logic       round;
		logic [6:0] round_idx;
		logic       fin_add;
		logic       reload;
		logic [2:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] byte_pos;
	} dp_stat_t;

	function automatic logic [31:0] round_f(input logic [6:0] t,
		input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		if (t < 7'd20) begin
			return (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			return b ^ c ^ d;
		end else if (t < 7'd60) begin
			return (b & c) | (b & d) | (c & d);
		end else begin
			return b ^ c ^ d;
		end
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		if (t < 7'd20) begin
			return K_R0;
		end else if (t < 7'd40) begin
			return K_R1;
		end else if (t < 7'd60) begin
			return K_R2;
		end else begin
			return K_R3;
		end
	endfunction

endpackage

>>> rtl/sha1e_datapath.sv
// Datapath: block buffer, schedule window, working variables, chaining words and length.
`timescale 1ns / 1ps

module sha1e_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha1e_pkg::dp_cmd_t  cmd,
	input  logic [7:0]        data_byte,
	output sha1e_pkg::dp_stat_t stat,
	output logic [31:0]       digest_word
);
	import sha1e_pkg::*;

	logic [511:0] win_q;
	logic [31:0]  chain_q [WORDS];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [63:0]  bit_count_q;
	logic [5:0]   pos_q;

	logic [7:0]  byte_val;
	logic [31:0] w0, w2, w8, w13, w_mix, w_new, tmp;

	assign w0  = win_q[511:480];
	assign w2  = win_q[447:416];
	assign w8  = win_q[255:224];
	assign w13 = win_q[95:64];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = (cmd.round_idx < 7'd16) ? w0 : {w_mix[30:0], w_mix[31]};
	assign tmp = {a_q[26:0], a_q[31:27]} + round_f(cmd.round_idx, b_q, c_q, d_q)
		+ e_q + round_k(cmd.round_idx) + w_new;

	always_comb begin
		case (cmd.src)
			SRC_DATA: byte_val = data_byte;
			SRC_MARK: byte_val = PAD_MARK;
			SRC_ZERO: byte_val = 8'h00;
			SRC_LEN:  byte_val = bit_count_q[{cmd.len_idx, 3'b000} +: 8];
			default:  byte_val = 8'h00;
		endcase
	end

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			3'd4:    digest_word = chain_q[4];
			default: digest_word = 32'h0;
		endcase
	end

	assign stat.byte_pos = pos_q;

	// byte buffer doubles as the schedule window: oldest word sits at the top
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= {win_q[503:0], byte_val};
		end else if (cmd.round) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= H_INIT;
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			d_q         <= '0;
			e_q         <= '0;
			bit_count_q <= '0;
			pos_q       <= '0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			if (cmd.load_work) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end else if (cmd.round) begin
				a_q <= tmp;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
			end
			if (cmd.fin_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end else if (cmd.reload) begin
				chain_q     <= H_INIT;
				bit_count_q <= '0;
			end
		end
	end

endmodule

>>> rtl/sha1e_ctrl.sv
// Controller: sequences byte loading, rounds, padding and digest output.
`timescale 1ns / 1ps

module sha1e_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                has_byte,
	input  logic                end_of_message,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          word_index,
	output logic                last_word,
	input  sha1e_pkg::dp_stat_t stat,
	output sha1e_pkg::dp_cmd_t  cmd
);
	import sha1e_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROUND,
		S_FINAL,
		S_PAD,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		P_MARK,
		P_ZERO,
		P_LEN,
		P_DONE
	} phase_t;

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [6:0] round_q, round_d;
	logic       fin_q, fin_d;
	logic [2:0] len_q, len_d;
	logic [2:0] idx_q, idx_d;
	logic       block_full;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign word_index = idx_q;
	assign last_word  = (idx_q == IDX_LAST);
	assign block_full = (stat.byte_pos == POS_LAST);

	always_comb begin
		cmd = '0;
		cmd.src       = SRC_DATA;
		cmd.round_idx = round_q;
		cmd.out_idx   = idx_q;
		state_d = state_q;
		phase_d = phase_q;
		round_d = round_q;
		fin_d   = fin_q;
		len_d   = len_q;
		idx_d   = idx_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.push  = has_byte;
					cmd.count = has_byte;
					phase_d   = P_MARK;
					fin_d     = end_of_message;
					if (has_byte && block_full) begin
						cmd.load_work = 1'b1;
						round_d = '0;
						state_d = S_ROUND;
					end else if (end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (round_q == ROUND_END) begin
					state_d = S_FINAL;
				end else begin
					round_d = round_q + 7'd1;
				end
			end
			S_FINAL: begin
				cmd.fin_add = 1'b1;
				if (!fin_q) begin
					state_d = S_IDLE;
				end else if (phase_q == P_DONE) begin
					idx_d   = '0;
					state_d = S_OUT;
				end else begin
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				cmd.push = 1'b1;
				case (phase_q)
					P_MARK: begin
						cmd.src = SRC_MARK;
						phase_d = P_ZERO;
					end
					P_ZERO: begin
						if (stat.byte_pos == POS_LEN) begin
							cmd.src     = SRC_LEN;
							cmd.len_idx = 3'd7;
							len_d       = 3'd6;
							phase_d     = P_LEN;
						end else begin
							cmd.src = SRC_ZERO;
						end
					end
					P_LEN: begin
						cmd.src     = SRC_LEN;
						cmd.len_idx = len_q;
						len_d       = len_q - 3'd1;
						if (len_q == 3'd0) begin
							phase_d = P_DONE;
						end
					end
					default: begin
						cmd.push = 1'b0;
					end
				endcase
				if (block_full) begin
					cmd.load_work = 1'b1;
					round_d = '0;
					state_d = S_ROUND;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					if (idx_q == IDX_LAST) begin
						cmd.reload = 1'b1;
						fin_d   = 1'b0;
						idx_d   = '0;
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= P_MARK;
			round_q <= '0;
			fin_q   <= 1'b0;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			round_q <= round_d;
			fin_q   <= fin_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
		end
	end

endmodule

>>> rtl/sha1_hash_engine_unit.sv
// Top level of the SHA-1 engine: byte input channel, digest word output channel.
`timescale 1ns / 1ps

// SHA-1 hash engine. Feed a message one byte per transfer (has_byte high), and
// close it with end_of_message high, alone or on the last byte. The digest then
// comes out as five transfers of 32-bit words, h0 first, with last_word high on
// the fifth; the engine reloads its initial values for the next message. A
// transfer with neither has_byte nor end_of_message changes nothing. Bytes are
// taken one per cycle while the engine is idle; the 64th byte of a block starts
// the compression, which runs 80 rounds, one round per cycle, on a single round
// unit and then folds the result into the chaining words. Closing a message
// pads one byte per cycle up to the 64-bit length field, pausing for one or two
// more compressions, then holds each digest word until the output side takes
// it. No input is taken during any of this work.

module sha1_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1e_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	sha1e_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_index     (word_index),
		.last_word      (last_word),
		.stat           (stat),
		.cmd            (cmd)
	);

	// buffer, rounds, chaining words and bit count
	sha1e_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.stat        (stat),
		.digest_word (digest_word)
	);

endmodule

>>> test/tb_sha1_hash_engine_unit.sv
// Self-checking testbench for the SHA-1 byte-stream hash engine.
`timescale 1ns / 1ps

// Holds a bit-true copy of the engine state and the queue of digest words still owed.
class sha1_digest_board;
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_entry_t;

	logic [31:0]   chain[5];
	logic [31:0]   window[16];
	logic [63:0]   msg_bits;
	logic [5:0]    blk_pos;
	digest_entry_t digest_q[$];
	int            n_errors;
	int            n_words;

	function new();
		n_errors = 0;
		n_words  = 0;
		foreach (window[i]) window[i] = 32'h0;
		restart();
	endfunction

	function void restart();
		chain[0] = 32'h67452301;
		chain[1] = 32'hEFCDAB89;
		chain[2] = 32'h98BADCFE;
		chain[3] = 32'h10325476;
		chain[4] = 32'hC3D2E1F0;
		msg_bits = 64'h0;
		blk_pos  = 6'd0;
	endfunction

	// 80 rounds over the current window, folded into the chaining words.
	function void compress();
		logic [31:0] a, b, c, d, e, f, k, w, sum;
		int t;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (t = 0; t < 80; t++) begin
			if (t < 16) begin
				w = window[t];
			end else begin
				w = window[(t + 13) % 16] ^ window[(t + 8) % 16] ^ window[(t + 2) % 16]
					^ window[t % 16];
				w = {w[30:0], w[31]};
				window[t % 16] = w;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			sum = {a[26:0], a[31:27]} + f + e + k + w;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = sum;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
		chain[4] += e;
	endfunction

	// Pack big-endian into the window; the 64th byte of a block compresses.
	function void add_byte(input logic [7:0] v);
		window[blk_pos[5:2]][31 - 8 * blk_pos[1:0] -: 8] = v;
		blk_pos = blk_pos + 6'd1;
		if (blk_pos == 6'd0) begin
			compress();
		end
	endfunction

	// Note one accepted input transfer and queue any digest words it closes.
	function void take_input(input logic [7:0] d, input logic has, input logic fin);
		logic [63:0]   len;
		digest_entry_t ent;
		int            i;
		if (has) begin
			add_byte(d);
			msg_bits += 64'd8;
		end
		if (!fin) begin
			return;
		end
		len = msg_bits;
		add_byte(8'h80);
		// zero-fill up to the length field at byte 56
		while (blk_pos != 6'd56) begin
			add_byte(8'h00);
		end
		for (i = 7; i >= 0; i--) begin
			add_byte(len[8 * i +: 8]);
		end
		for (i = 0; i < 5; i++) begin
			ent.word = chain[i];
			ent.idx  = 3'(i);
			ent.last = (i == 4);
			digest_q.push_back(ent);
		end
		restart();
	endfunction

	task report(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		n_errors++;
	endtask

	// Compare one digest transfer against the oldest owed word.
	task check_word(input logic [31:0] word, input logic [2:0] idx, input logic last);
		digest_entry_t ent;
		if (digest_q.size() == 0) begin
			report($sformatf("unexpected digest word %08h idx %0d", word, idx));
			return;
		end
		ent = digest_q.pop_front();
		n_words++;
		if (word !== ent.word) begin
			report($sformatf("digest_word %08h, want %08h (idx %0d)", word, ent.word, ent.idx));
		end
		if (idx !== ent.idx) begin
			report($sformatf("word_index %0d, want %0d", idx, ent.idx));
		end
		if (last !== ent.last) begin
			report($sformatf("last_word %0b, want %0b (idx %0d)", last, ent.last, ent.idx));
		end
	endtask

	function int pending();
		return digest_q.size();
	endfunction
endclass

module tb_sha1_hash_engine_unit;

	// Generous cap: several times the slowest legal run (long sender gaps on every
	// item, long receiver gaps on every digest word, the one long hold-off, and the
	// compressions plus padding of each message).
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned ITEM_TARGET  = 250;
	localparam int unsigned MIN_MESSAGES = 6;
	localparam int unsigned LONG_HOLD    = 800;
	// Drain time after the last word: covers padding plus two block compressions.
	localparam int unsigned TAIL_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha1_digest_board board;

	int unsigned cycle_count;
	int unsigned byte_items;
	bit          no_idle;
	bit          hold_request;

	sha1_hash_engine_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.has_byte       (has_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length for either side: mostly none or short, now and then long.
	// Returns zero throughout a no-idle stretch.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(99);
		if (no_idle || r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(12, 40);
	endfunction

	// Offer one input transfer after an optional gap and hold it until taken.
	// Drive at the falling edge, sample the handshake at the rising edge.
	task automatic push_item(input logic [7:0] d, input logic has, input logic fin);
		int unsigned gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= d;
		has_byte       <= has;
		end_of_message <= fin;
		do @(posedge clk); while (!in_ready);
		board.take_input(d, has, fin);
		if (has || fin) begin
			byte_items++;
		end
	endtask

	// Send a message of random bytes. Close it on the last byte or with a bare
	// end transfer carrying junk data; sprinkle idle transfers as noise.
	task automatic send_message(input int unsigned len);
		bit          close_on_byte;
		int unsigned i;
		close_on_byte = (len > 0) && $urandom_range(1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8) begin
				push_item(8'($urandom), 1'b0, 1'b0);
			end
			push_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
		end
		if (!close_on_byte) begin
			push_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	// Hold the sender until every owed digest word has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Message lengths: mostly short, a good share on the padding boundaries
	// (55 fits one block, 56 and up spill the length into a second one).
	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50) begin
			return $urandom_range(0, 12);
		end
		if (r < 80) begin
			case ($urandom_range(6))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				default: return 119;
			endcase
		end
		return $urandom_range(13, 130);
	endfunction

	// Output side: random back-pressure, plus one long hold-off on request.
	task automatic run_receiver();
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready  <= 1'b1;
				stall_left = idle_len();
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_word(digest_word, word_index, last_word);
			end
		end
	endtask

	// Watchdog: end the run as failed if it ever runs past the limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int unsigned msg_count;
		board          = new();
		byte_items     = 0;
		no_idle        = 1'b0;
		hold_request   = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = 8'h00;
		has_byte       = 1'b0;
		end_of_message = 1'b0;
		out_ready      = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fork
			run_receiver();
		join_none

		// Directed part.
		// Empty message; the junk data byte must be ignored.
		push_item(8'hFF, 1'b0, 1'b1);
		// Idle transfer: no state change, no digest.
		push_item(8'hA5, 1'b0, 1'b0);
		// Byte and end together, at both byte extremes.
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hFF, 1'b1, 1'b1);
		// "abc", closed by a bare end transfer.
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		// Idle between messages, then another empty message.
		push_item(8'h5A, 1'b0, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
		// Bytes that look like padding marks.
		push_item(8'h80, 1'b1, 1'b0);
		push_item(8'h7F, 1'b1, 1'b0);
		push_item(8'h80, 1'b0, 1'b1);
		drain_results();

		// Random part: well-formed messages of random content and length.
		byte_items = 0;
		msg_count  = 0;
		while (byte_items < ITEM_TARGET || msg_count < MIN_MESSAGES) begin
			// Stall the output for a long stretch while the input keeps coming.
			if (msg_count == 2) begin
				hold_request = 1'b1;
			end
			// Run a stretch with no idling on either side.
			no_idle = (msg_count >= 4 && msg_count < 6);
			// Pause once the sender until everything owed has arrived.
			if (msg_count == 5) begin
				drain_results();
			end
			send_message(pick_length());
			msg_count++;
		end
		no_idle = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.n_errors == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
